@@ rtl/effective_target_from_compact_assert.svh @@
// Assertion macros used by the checker efft_chk.
`ifndef EFFECTIVE_TARGET_FROM_COMPACT_ASSERT_SVH
`define EFFECTIVE_TARGET_FROM_COMPACT_ASSERT_SVH

// Same-cycle implication.
`define EFFT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define EFFT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/efft_pkg.sv @@
package efft_pkg;

    localparam int WW = 769;
    localparam int TW = 257;

    localparam logic [31:0] MAX_COMPACT = 32'h207fffff;
    localparam logic [TW-1:0] POW256 = {1'b1, {(TW-1){1'b0}}};

    typedef struct packed {
        logic [TW-1:0] t;
        logic          bad;
    } t_dec;

    typedef struct packed {
        logic inv;
        logic cin;
    } t_alu_ctl;

    function automatic t_dec decode(input logic [31:0] c);
        logic [7:0]  size;
        logic [22:0] word;
        logic [22:0] w;
        logic [4:0]  len;
        logic [11:0] sh;
        t_dec        r;
        size = c[31:24];
        word = c[22:0];
        len  = '0;
        sh   = '0;
        w    = word;
        r.t  = '0;
        for (int i = 0; i < 23; i++) begin
            if (word[i]) len = 5'(i + 1);
        end
        if (size <= 8'd3) begin
            unique case (size[1:0])
                2'd0: w = '0;
                2'd1: w = word >> 16;
                2'd2: w = word >> 8;
                2'd3: w = word;
                default: w = word;
            endcase
            r.t = {{(TW-23){1'b0}}, w};
        end else begin
            sh = {1'b0, size - 8'd3, 3'b000};
            if (word != '0 && (sh + {7'b0, len}) >= 12'd257) begin
                r.t = POW256;
            end else begin
                r.t = {{(TW-23){1'b0}}, word} << sh[8:0];
            end
        end
        r.bad = c[23] && (w != '0);
        return r;
    endfunction

endpackage

@@ rtl/efft_in_if.sv @@
interface efft_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] block_target;
    logic [31:0] ann_target;
    logic [63:0] ann_count;

    modport source (output valid, block_target, ann_target, ann_count, input ready);
    modport sink (input valid, block_target, ann_target, ann_count, output ready);
endinterface

@@ rtl/efft_out_if.sv @@
interface efft_out_if;
    logic        valid;
    logic        ready;
    logic [29:0] effective_target;
    logic        invalid;

    modport source (output valid, effective_target, invalid, input ready);
    modport sink (input valid, effective_target, invalid, output ready);
endinterface

@@ rtl/efft_alu.sv @@
module efft_alu (
    input  logic [efft_pkg::WW-1:0] i_a,
    input  logic [efft_pkg::WW-1:0] i_b,
    input  efft_pkg::t_alu_ctl      i_ctl,
    output logic [efft_pkg::WW-1:0] o_sum,
    output logic                    o_cout
);
    logic [efft_pkg::WW-1:0] b_eff;

    assign b_eff = i_ctl.inv ? ~i_b : i_b;
    assign {o_cout, o_sum} = {1'b0, i_a} + {1'b0, b_eff} + {{efft_pkg::WW{1'b0}}, i_ctl.cin};
endmodule

@@ rtl/effective_target_from_compact.sv @@
// Effective compact target unit.
// Input channel i_in carries block_target, ann_target and ann_count; output
// channel o_out returns effective_target and invalid, one result per input.
// Beats move on valid and ready both high at the rising edge of i_clk.
// i_in.ready is high only while the sequencer is idle; one item is worked at
// a time. Divisions, multiplies and the final subtract share one 769-bit
// add/subtract unit: bit-serial restoring divisions and shift-and-add
// multiplies, one bit per cycle. A regular item runs two 257-step work
// divisions, a 64-step count square, 257- and 513-step multiplies, two
// 759-step divisions, a 257-step final division and 1 to 34 encode steps.
// A zero count or zero announcement work goes straight to the encode steps,
// an invalid input straight to the output register.
// The result sits in an output register; a stalled receiver holds the next
// result in the sequencer until the register frees, and no new beat is taken.
// Synchronous reset returns the sequencer to idle and drops o_out.valid.
module effective_target_from_compact (
    input  logic        i_clk,
    input  logic        i_rst_n,
    efft_in_if.sink     i_in,
    efft_out_if.source  o_out
);
    localparam int WW = efft_pkg::WW;
    localparam int TW = efft_pkg::TW;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_BWD  = 4'd1;
    localparam logic [3:0] ST_AWD  = 4'd2;
    localparam logic [3:0] ST_CHK  = 4'd3;
    localparam logic [3:0] ST_CSQ  = 4'd4;
    localparam logic [3:0] ST_M1   = 4'd5;
    localparam logic [3:0] ST_M2   = 4'd6;
    localparam logic [3:0] ST_DAW  = 4'd7;
    localparam logic [3:0] ST_DCN  = 4'd8;
    localparam logic [3:0] ST_FIN  = 4'd9;
    localparam logic [3:0] ST_SUB  = 4'd10;
    localparam logic [3:0] ST_DFN  = 4'd11;
    localparam logic [3:0] ST_ENC  = 4'd12;
    localparam logic [3:0] ST_OUT  = 4'd13;

    logic [3:0]    r_state, n_state;
    logic [9:0]    r_cnt, n_cnt;
    logic [WW-1:0] r_a, n_a;
    logic [WW-1:0] r_q, n_q;
    logic [TW-1:0] r_b, n_b;
    logic [TW-1:0] r_ta, n_ta;
    logic [TW-1:0] r_bw, n_bw;
    logic [TW-1:0] r_aw, n_aw;
    logic [63:0]   r_count, n_count;
    logic [127:0]  r_c2, n_c2;
    logic [5:0]    r_nb, n_nb;
    logic          r_bad, n_bad;
    logic          r_ov, n_ov;
    logic [29:0]   r_oeff, n_oeff;
    logic          r_oinv, n_oinv;

    logic [WW-1:0]      alu_a, alu_b, alu_sum;
    logic               alu_cout;
    efft_pkg::t_alu_ctl alu_ctl;

    efft_pkg::t_dec dec_b, dec_a;
    logic           is_div, is_mul, last;
    logic [WW-1:0]  rem_sh, div_a, div_q;
    logic [23:0]    comp;
    logic [6:0]     nb_fix;
    logic [31:0]    cw;

    efft_alu u_alu (
        .i_a    (alu_a),
        .i_b    (alu_b),
        .i_ctl  (alu_ctl),
        .o_sum  (alu_sum),
        .o_cout (alu_cout)
    );

    assign dec_b = efft_pkg::decode(i_in.block_target);
    assign dec_a = efft_pkg::decode(i_in.ann_target);

    assign is_div = (r_state == ST_BWD) || (r_state == ST_AWD) || (r_state == ST_DAW)
                 || (r_state == ST_DCN) || (r_state == ST_DFN);
    assign is_mul = (r_state == ST_CSQ) || (r_state == ST_M1) || (r_state == ST_M2);
    assign last   = (r_cnt == '0);

    assign rem_sh = {r_a[WW-2:0], r_q[WW-1]};
    assign div_a  = alu_cout ? alu_sum : rem_sh;
    assign div_q  = {r_q[WW-2:0], alu_cout};

    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_ctl = '0;
        if (is_div) begin
            alu_a       = rem_sh;
            alu_b       = {{(WW-TW){1'b0}}, r_b};
            alu_ctl.inv = 1'b1;
            alu_ctl.cin = !((r_state == ST_BWD) || (r_state == ST_AWD));
        end else if (is_mul) begin
            alu_a = {r_a[WW-2:0], 1'b0};
            alu_b = r_q[WW-1] ? {{(WW-TW){1'b0}}, r_b} : '0;
        end else if (r_state == ST_SUB) begin
            alu_a       = {{(WW-TW){1'b0}}, efft_pkg::POW256};
            alu_b       = r_q;
            alu_ctl.inv = 1'b1;
            alu_ctl.cin = 1'b1;
        end
    end

    always_comb begin
        comp   = r_q[263:240];
        nb_fix = {1'b0, r_nb};
        if (comp[23]) begin
            comp   = {8'b0, comp[23:8]};
            nb_fix = nb_fix + 7'd1;
        end
        cw = {1'b0, nb_fix, comp};
        if (cw > efft_pkg::MAX_COMPACT) cw = efft_pkg::MAX_COMPACT;
    end

    assign i_in.ready             = (r_state == ST_IDLE);
    assign o_out.valid            = r_ov;
    assign o_out.effective_target = r_oeff;
    assign o_out.invalid          = r_oinv;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_a     = r_a;
        n_q     = r_q;
        n_b     = r_b;
        n_ta    = r_ta;
        n_bw    = r_bw;
        n_aw    = r_aw;
        n_count = r_count;
        n_c2    = r_c2;
        n_nb    = r_nb;
        n_bad   = r_bad;
        n_ov    = r_ov;
        n_oeff  = r_oeff;
        n_oinv  = r_oinv;

        if (r_ov && o_out.ready) n_ov = 1'b0;

        if (is_div) begin
            n_a = div_a;
            n_q = div_q;
        end else if (is_mul) begin
            n_a = alu_sum;
            n_q = {r_q[WW-2:0], 1'b0};
        end
        if (is_div || is_mul) n_cnt = r_cnt - 10'd1;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    if (dec_b.bad || dec_a.bad) begin
                        n_bad   = 1'b1;
                        n_state = ST_OUT;
                    end else begin
                        n_b     = dec_b.t;
                        n_ta    = dec_a.t;
                        n_count = i_in.ann_count;
                        n_a     = '0;
                        n_q     = {1'b1, {(WW-1){1'b0}}};
                        n_cnt   = 10'(TW - 1);
                        n_state = ST_BWD;
                    end
                end
            end
            ST_BWD: begin
                if (last) begin
                    n_bw    = div_q[TW-1:0];
                    n_a     = '0;
                    n_q     = {1'b1, {(WW-1){1'b0}}};
                    n_b     = r_ta;
                    n_cnt   = 10'(TW - 1);
                    n_state = ST_AWD;
                end
            end
            ST_AWD: begin
                if (last) begin
                    n_aw    = div_q[TW-1:0];
                    n_state = ST_CHK;
                end
            end
            ST_CHK: begin
                if (r_aw == '0 || r_count == '0) begin
                    n_q     = '0;
                    n_nb    = 6'd33;
                    n_state = ST_ENC;
                end else begin
                    n_a     = '0;
                    n_q     = {r_count, {(WW-64){1'b0}}};
                    n_b     = {{(TW-64){1'b0}}, r_count};
                    n_cnt   = 10'd63;
                    n_state = ST_CSQ;
                end
            end
            ST_CSQ: begin
                if (last) begin
                    n_c2    = alu_sum[127:0];
                    n_a     = '0;
                    n_q     = {r_bw, {(WW-TW){1'b0}}};
                    n_b     = r_bw;
                    n_cnt   = 10'(TW - 1);
                    n_state = ST_M1;
                end
            end
            ST_M1: begin
                if (last) begin
                    n_a     = '0;
                    n_q     = {alu_sum[512:0], {(WW-513){1'b0}}};
                    n_b     = r_bw;
                    n_cnt   = 10'd512;
                    n_state = ST_M2;
                end
            end
            ST_M2: begin
                if (last) begin
                    n_a     = '0;
                    n_q     = {alu_sum[WW-1:10], 10'b0};
                    n_b     = r_aw;
                    n_cnt   = 10'd758;
                    n_state = ST_DAW;
                end
            end
            ST_DAW: begin
                if (last) begin
                    n_a     = '0;
                    n_q     = {div_q[758:0], 10'b0};
                    n_b     = {{(TW-128){1'b0}}, r_c2};
                    n_cnt   = 10'd758;
                    n_state = ST_DCN;
                end
            end
            ST_DCN: begin
                if (last) n_state = ST_FIN;
            end
            ST_FIN: begin
                n_nb = 6'd33;
                if (r_q == '0) begin
                    n_q     = {{(WW-TW){1'b0}}, efft_pkg::POW256};
                    n_state = ST_ENC;
                end else if (r_q[WW-1:TW-1] != '0) begin
                    n_q     = '0;
                    n_state = ST_ENC;
                end else begin
                    n_state = ST_SUB;
                end
            end
            ST_SUB: begin
                n_b     = r_q[TW-1:0];
                n_q     = {alu_sum[TW-1:0], {(WW-TW){1'b0}}};
                n_a     = '0;
                n_cnt   = 10'(TW - 1);
                n_state = ST_DFN;
            end
            ST_DFN: begin
                if (last) begin
                    n_nb    = 6'd33;
                    n_state = ST_ENC;
                end
            end
            ST_ENC: begin
                if (r_nb != '0 && r_q[263:256] == '0) begin
                    n_q  = {r_q[WW-9:0], 8'b0};
                    n_nb = r_nb - 6'd1;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_ov || o_out.ready) begin
                    n_ov    = 1'b1;
                    n_oinv  = r_bad;
                    n_oeff  = r_bad ? efft_pkg::MAX_COMPACT[29:0] : cw[29:0];
                    n_bad   = 1'b0;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
            r_bad   <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            r_bad   <= n_bad;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a     <= n_a;
        r_q     <= n_q;
        r_b     <= n_b;
        r_ta    <= n_ta;
        r_bw    <= n_bw;
        r_aw    <= n_aw;
        r_count <= n_count;
        r_c2    <= n_c2;
        r_nb    <= n_nb;
        r_oeff  <= n_oeff;
        r_oinv  <= n_oinv;
    end
endmodule

@@ rtl/efft_chk.sv @@
`include "effective_target_from_compact_assert.svh"

module efft_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [29:0] i_eff,
    input logic        i_invalid
);
    `EFFT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "result beat dropped while stalled")
    `EFFT_ASSERT_NOW(a_inv_sat, i_clk, i_rst_n, i_out_valid && i_invalid, i_eff == efft_pkg::MAX_COMPACT[29:0], "invalid beat not saturated")
    `EFFT_ASSERT_NOW(a_sat_range, i_clk, i_rst_n, i_out_valid, {2'b00, i_eff} <= efft_pkg::MAX_COMPACT, "target above saturation")
    `EFFT_ASSERT_NEXT(a_busy, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready, "input taken while busy")
endmodule

bind effective_target_from_compact efft_chk u_efft_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_eff       (o_out.effective_target),
    .i_invalid   (o_out.invalid)
);

@@ tb/sv/testbench.sv @@
module testbench;
    localparam int NB = 832;
    localparam longint CYCLE_LIMIT = 6000000;
    localparam logic [NB-1:0] P256 = {{(NB-257){1'b0}}, 1'b1, 256'b0};

    typedef logic [NB-1:0] t_big;

    typedef struct {
        logic [29:0] tgt;
        logic        inv;
    } t_result;

    class target_scoreboard;
        t_result pending[$];
        int      errors = 0;

        function automatic t_big unpack_target(input logic [31:0] c, inout logic bad);
            int          size;
            int          sh;
            int          len;
            logic [22:0] word;
            t_big        t;
            size = c[31:24];
            word = c[22:0];
            len  = 0;
            if (size <= 3) begin
                word = word >> (8 * (3 - size));
                t = t_big'(word);
            end else begin
                sh = 8 * (size - 3);
                for (int i = 0; i < 23; i++) if (word[i]) len = i + 1;
                if (word != 0 && sh + len >= 257) t = P256;
                else t = t_big'(word) << sh;
            end
            if (c[23] && word != 0) bad = 1'b1;
            return t;
        endfunction

        function automatic logic [31:0] pack_target(input t_big d);
            int          nbits;
            int          nbytes;
            logic [31:0] comp;
            t_big        s;
            nbits = 0;
            for (int i = 0; i < NB; i++) if (d[i]) nbits = i + 1;
            nbytes = (nbits + 7) / 8;
            if (nbytes <= 3) begin
                comp = d[31:0] << (8 * (3 - nbytes));
            end else begin
                s = d >> (8 * (nbytes - 3));
                comp = {8'b0, s[23:0]};
            end
            if (comp[23]) begin
                comp = comp >> 8;
                nbytes++;
            end
            comp = comp | (32'(nbytes) << 24);
            return (comp > efft_pkg::MAX_COMPACT) ? efft_pkg::MAX_COMPACT : comp;
        endfunction

        function automatic void note(input logic [31:0] bt, input logic [31:0] at,
                                     input logic [63:0] cnt);
            logic        bad;
            t_big        bw, aw, w, d, cs;
            logic [31:0] comp;
            t_result     r;
            bad = 1'b0;
            bw = unpack_target(bt, bad);
            aw = unpack_target(at, bad);
            if (bad) begin
                r.tgt = efft_pkg::MAX_COMPACT[29:0];
                r.inv = 1'b1;
            end else begin
                bw = P256 / (bw + 1);
                aw = P256 / (aw + 1);
                if (aw == 0 || cnt == 0) begin
                    w = P256;
                end else begin
                    w = ((bw * bw * bw) >> 10) / aw;
                    cs = t_big'(cnt) * t_big'(cnt);
                    w = w / cs;
                end
                if (w == 0) d = P256;
                else if (w >= P256) d = 0;
                else d = (P256 - w) / w;
                comp = pack_target(d);
                r.tgt = comp[29:0];
                r.inv = 1'b0;
            end
            pending.push_back(r);
        endfunction

        function automatic void check(input logic [29:0] tgt, input logic inv);
            t_result e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected beat tgt=%h inv=%b", $time, tgt, inv);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (tgt !== e.tgt) begin
                $display("%0t: effective_target expected %h actual %h", $time, e.tgt, tgt);
                errors++;
            end
            if (inv !== e.inv) begin
                $display("%0t: invalid expected %b actual %b", $time, e.inv, inv);
                errors++;
            end
        endfunction
    endclass

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    int     tx_idle = 0;
    int     rx_idle = 0;
    longint cycles = 0;

    target_scoreboard sb = new();

    efft_in_if  in_if();
    efft_out_if out_if();

    effective_target_from_compact DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        in_if.valid = 1'b0;
        in_if.block_target = '0;
        in_if.ann_target = '0;
        in_if.ann_count = '0;
        out_if.ready = 1'b0;
    end

    always @(posedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= rx_idle);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready)
            sb.check(out_if.effective_target, out_if.invalid);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send(input logic [31:0] bt, input logic [31:0] at, input logic [63:0] cnt);
        if ($urandom_range(99) < tx_idle) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.block_target <= bt;
        in_if.ann_target <= at;
        in_if.ann_count <= cnt;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        sb.note(bt, at, cnt);
    endtask

    function automatic logic [31:0] rand_compact();
        logic [31:0] c;
        if ($urandom_range(9) == 0) return $urandom;
        c[31:24] = 8'($urandom_range(0, 34));
        c[23] = ($urandom_range(15) == 0);
        c[22:0] = 23'($urandom) >> $urandom_range(0, 22);
        return c;
    endfunction

    function automatic logic [63:0] rand_count();
        case ($urandom_range(9))
            0: return '0;
            1: return {$urandom, $urandom};
            2: return 64'd1;
            default: return 64'($urandom_range(1, 1000));
        endcase
    endfunction

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send(32'h00000000, 32'h00000000, 64'd0);
        send(32'hffffffff, 32'hffffffff, '1);
        send(32'h1d00ffff, 32'h2000ffff, 64'd1);
        send(32'h1d00ffff, 32'h1e00ffff, 64'd3);
        send(32'h04800000, 32'h1d00ffff, 64'd2);
        send(32'h03800001, 32'h1d00ffff, 64'd2);
        send(32'h1d00ffff, 32'h20812345, 64'd2);
        send(32'h00812345, 32'h01923456, 64'd5);
        send(32'h01123456, 32'h02123456, 64'd7);
        send(32'h22400000, 32'h1d00ffff, 64'd1);
        send(32'h1d00ffff, 32'hff7fffff, 64'd1);
        send(32'h207fffff, 32'h03000001, '1);
        send(32'h03000001, 32'h207fffff, 64'd1);
        send(32'h1d00ffff, 32'h1d00ffff, 64'd0);
        send(32'h217fffff, 32'h21000001, 64'h8000000000000000);
        send(32'h1f7fffff, 32'h00000000, 64'hffffffff);
        send(32'h7f000000, 32'h1c5a5a5a, 64'd40);
        send(32'h1b0404cb, 32'h1a012345, 64'd1);

        in_if.valid <= 1'b0;
        wait (sb.pending.size() == 0);
        @(posedge i_clk);

        for (int k = 0; k < 190; k++) begin
            if (k < 60) begin
                tx_idle = 36;
                rx_idle = 47;
            end else if (k < 120) begin
                tx_idle = 47;
                rx_idle = 36;
            end else begin
                tx_idle = 0;
                rx_idle = 0;
            end
            send(rand_compact(), rand_compact(), rand_count());
        end
        in_if.valid <= 1'b0;

        wait (sb.pending.size() == 0);
        repeat (4000) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
